// ===== hdl/ospt_pkg.sv =====
package ospt_pkg;

	localparam int MAX_FFT   = 4096;
	localparam int MAX_ANTS  = 64;
	localparam int BIN_W     = 12;
	localparam int CFG_W     = 13;
	localparam int ADDR_W    = 18;
	localparam int SMP_W     = 16;
	localparam int DIV_W     = 13;
	localparam int DIV_CNT_W = 4;

	localparam logic [12:0] FFT_SIZE_RST   = 13'd2048;
	localparam logic [11:0] DATA_START_RST = 12'd424;
	localparam logic [12:0] DATA_COUNT_RST = 13'd1200;
	localparam logic [12:0] BLOCK_LEN_RST  = 13'd16;
	localparam logic [6:0]  ANT_COUNT_RST  = 7'd8;

	typedef enum logic [2:0] {
		REG_FFT_SIZE   = 3'd0,
		REG_DATA_START = 3'd1,
		REG_DATA_COUNT = 3'd2,
		REG_BLOCK_LEN  = 3'd3,
		REG_ANT_COUNT  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_PILOT = 2'd1,
		KIND_CAL   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		TRK_START,
		TRK_SPAN,
		TRK_KDIV,
		TRK_BASE,
		TRK_RUN
	} trk_state_t;

	typedef struct packed {
		logic [12:0] fft_size;
		logic [11:0] data_start;
		logic [12:0] data_count;
		logic [12:0] block_len;
		logic [6:0]  antenna_count;
	} cfg_t;

	// tracker status toward the input stage
	typedef struct packed {
		logic        busy;
		logic [11:0] bin;
		logic [11:0] off;
		logic [17:0] base;
		logic [12:0] span;
	} trk_t;

	// one accepted word with its position state
	typedef struct packed {
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
		logic signed [15:0] pilot_re;
		logic signed [15:0] pilot_im;
		logic [1:0]         kind;
		logic [5:0]         ant;
		logic [11:0]        k;
		logic [11:0]        off;
		logic [17:0]        base;
	} item_t;

	typedef struct packed {
		logic [17:0]        dest_index;
		logic signed [15:0] value_re;
		logic signed [15:0] value_im;
		logic               to_cal;
		logic               sat;
	} res_t;

endpackage

// ===== hdl/ospt_div.sv =====
// restoring divider, one quotient bit per cycle
module ospt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [12:0] quo,
	output logic [12:0] rem
);

	logic [12:0] rem_q;
	logic [12:0] quo_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [13:0] trial;
	logic        ge;
	logic [13:0] diff;

	always_comb begin
		trial = {rem_q, quo_q[12]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				cnt_q <= ospt_pkg::DIV_CNT_W'(ospt_pkg::DIV_W - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? diff[12:0] : trial[12:0];
				quo_q <= {quo_q[11:0], ge};
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/ospt_track.sv =====
// bin counter plus incremental block offset / block base; recomputed by division
// after reset and after every register write
module ospt_track (
	input  logic              clk,
	input  logic              arst_n,
	input  ospt_pkg::cfg_t    cfg,
	input  logic              cfg_we,
	input  logic              adv,
	output ospt_pkg::trk_t    trk
);

	ospt_pkg::trk_state_t state_q, state_d;

	logic [11:0] bin_q;
	logic [11:0] off_q;
	logic [17:0] base_q;
	logic [12:0] span_q;
	logic [17:0] stride_q;

	logic        div_start;
	logic [12:0] div_dividend;
	logic        div_done;
	logic [12:0] div_quo;
	logic [12:0] div_rem;

	logic [12:0] size;
	logic [6:0]  ants;
	logic [12:0] bin_inc;
	logic        bin_wrap;
	logic [11:0] bin_nx;
	logic [12:0] off_inc;
	logic        off_wrap;
	logic [11:0] k_cur;
	logic [19:0] stride_p;
	logic [30:0] base_p;

	ospt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg.block_len),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		size = (cfg.fft_size > 13'(ospt_pkg::MAX_FFT)) ? 13'(ospt_pkg::MAX_FFT)
			: cfg.fft_size;
		ants = (cfg.antenna_count > 7'(ospt_pkg::MAX_ANTS)) ? 7'(ospt_pkg::MAX_ANTS)
			: cfg.antenna_count;
		bin_inc  = {1'b0, bin_q} + 13'd1;
		bin_wrap = (size <= 13'd1) || (bin_inc >= size);
		bin_nx   = bin_wrap ? '0 : bin_inc[11:0];
		off_inc  = {1'b0, off_q} + 13'd1;
		off_wrap = off_inc == cfg.block_len;
		k_cur    = bin_q - cfg.data_start;
		stride_p = cfg.block_len * ants;
		base_p   = div_quo * stride_q;
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = (state_q == ospt_pkg::TRK_START) ? cfg.data_count : {1'b0, k_cur};
		unique case (state_q)
			ospt_pkg::TRK_START: begin
				div_start = 1'b1;
				state_d   = ospt_pkg::TRK_SPAN;
			end
			ospt_pkg::TRK_SPAN: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ospt_pkg::TRK_KDIV;
				end
			end
			ospt_pkg::TRK_KDIV: begin
				if (div_done)
					state_d = ospt_pkg::TRK_BASE;
			end
			ospt_pkg::TRK_BASE: state_d = ospt_pkg::TRK_RUN;
			ospt_pkg::TRK_RUN:  state_d = ospt_pkg::TRK_RUN;
			default:            state_d = ospt_pkg::TRK_START;
		endcase
		if (cfg_we)
			state_d = ospt_pkg::TRK_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ospt_pkg::TRK_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			off_q    <= '0;
			base_q   <= '0;
			span_q   <= '0;
			stride_q <= '0;
		end else begin
			if (state_q == ospt_pkg::TRK_START)
				stride_q <= stride_p[17:0];
			if (state_q == ospt_pkg::TRK_SPAN && div_done)
				span_q <= cfg.data_count - div_rem;
			if (state_q == ospt_pkg::TRK_KDIV && div_done)
				off_q <= div_rem[11:0];
			if (state_q == ospt_pkg::TRK_BASE)
				base_q <= base_p[17:0];
			if (adv) begin
				bin_q <= bin_nx;
				if (bin_nx == cfg.data_start) begin
					off_q  <= '0;
					base_q <= '0;
				end else if (off_wrap) begin
					off_q  <= '0;
					base_q <= base_q + stride_q;
				end else begin
					off_q  <= off_inc[11:0];
				end
			end
		end
	end

	always_comb begin
		trk.busy = state_q != ospt_pkg::TRK_RUN;
		trk.bin  = bin_q;
		trk.off  = off_q;
		trk.base = base_q;
		trk.span = span_q;
	end

endmodule

// ===== hdl/ospt_dp.sv =====
// conjugate pilot multiply with round/saturate, destination address
module ospt_dp (
	input  ospt_pkg::item_t item,
	input  ospt_pkg::cfg_t  cfg,
	output ospt_pkg::res_t  res
);

	function automatic logic [16:0] rnd_sat(input logic signed [32:0] acc);
		logic signed [33:0] r;
		logic signed [18:0] q;
		logic [16:0]        o;
		r = {acc[32], acc} + 34'sd16384;
		q = r[33:15];
		if (q > 19'sd32767)
			o = {1'b1, 16'h7FFF};
		else if (q < -19'sd32768)
			o = {1'b1, 16'h8000};
		else
			o = {1'b0, q[15:0]};
		return o;
	endfunction

	logic signed [31:0] p_rr, p_ii, p_ir, p_ri;
	logic signed [32:0] acc_re, acc_im;
	logic [16:0]        rs_re, rs_im;
	logic [18:0]        cal_p;
	logic [18:0]        ab_p;
	logic [17:0]        cal_addr;
	logic [17:0]        dat_addr;
	logic               pilot;
	logic               cal;

	always_comb begin
		pilot  = item.kind == ospt_pkg::KIND_PILOT;
		cal    = item.kind == ospt_pkg::KIND_CAL;
		p_rr   = item.sample_re * item.pilot_re;
		p_ii   = item.sample_im * item.pilot_im;
		p_ir   = item.sample_im * item.pilot_re;
		p_ri   = item.sample_re * item.pilot_im;
		acc_re = {p_rr[31], p_rr} + {p_ii[31], p_ii};
		acc_im = {p_ir[31], p_ir} - {p_ri[31], p_ri};
		rs_re  = rnd_sat(acc_re);
		rs_im  = rnd_sat(acc_im);

		cal_p    = item.ant * cfg.data_count;
		ab_p     = item.ant * cfg.block_len;
		cal_addr = cal_p[17:0] + 18'(item.k);
		dat_addr = item.base + ab_p[17:0] + 18'(item.off);

		res.dest_index = cal ? cal_addr : dat_addr;
		res.value_re   = pilot ? rs_re[15:0] : item.sample_re;
		res.value_im   = pilot ? rs_im[15:0] : item.sample_im;
		res.to_cal     = cal;
		res.sat        = pilot && (rs_re[16] || rs_im[16]);
	end

endmodule

// ===== hdl/ofdm_subcarrier_pilot_transpose.sv =====
// An accepted word passes the input register, then the result register, to the master
// side; m_axis_tready low holds it. Dropped bins (outside the passed data span) leave no result.
// Throughput: one word per cycle while the tracker is not busy and the master side does not stall.
// Reset (arst_n low, async): registers return to defaults, bin counter to 0, then the position
// tracker runs two 13-step serial divisions with s_axis_tready low.
// Every register write repeats that recompute; write only while no word is in flight.
module ofdm_subcarrier_pilot_transpose (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// FFT bin input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // sample_re, sample_im, pilot_re, pilot_im
	input  logic [7:0]  s_axis_tuser,   // symbol_kind[1:0], antenna[7:2]
	// addressed result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // dest_index, value_re, value_im, zero pad
	output logic [1:0]  m_axis_tuser,   // to_calibration, saturated
	output logic        m_axis_tlast
);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	ospt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fft_size      <= ospt_pkg::FFT_SIZE_RST;
			cfg_q.data_start    <= ospt_pkg::DATA_START_RST;
			cfg_q.data_count    <= ospt_pkg::DATA_COUNT_RST;
			cfg_q.block_len     <= ospt_pkg::BLOCK_LEN_RST;
			cfg_q.antenna_count <= ospt_pkg::ANT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (ospt_pkg::reg_idx_t'(cfg_index))
				ospt_pkg::REG_FFT_SIZE:   cfg_q.fft_size      <= cfg_data;
				ospt_pkg::REG_DATA_START: cfg_q.data_start    <= cfg_data[11:0];
				ospt_pkg::REG_DATA_COUNT: cfg_q.data_count    <= cfg_data;
				ospt_pkg::REG_BLOCK_LEN:  cfg_q.block_len     <= cfg_data;
				ospt_pkg::REG_ANT_COUNT:  cfg_q.antenna_count <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// bin position tracker: bin counter, in-block offset, block base
	// ---------------------------------------------------------------
	ospt_pkg::trk_t trk;
	logic           s_fire;

	ospt_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cfg_we (cfg_we),
		.adv    (s_fire),
		.trk    (trk)
	);

	// ---------------------------------------------------------------
	// input stage: decode pass/last against the current bin position
	// ---------------------------------------------------------------
	logic [1:0]  kind_in;
	logic [11:0] k_in;
	logic        pass_in;
	logic        last_in;

	ospt_pkg::item_t item_s1;
	logic            valid_s1;
	logic            pass_s1;
	logic            last_s1;

	ospt_pkg::res_t res_d;
	ospt_pkg::res_t res_s2;
	logic           valid_s2;
	logic           last_s2;

	logic out_free;
	logic s1_move;
	logic m_fire;

	always_comb begin
		kind_in = s_axis_tuser[1:0];
		k_in    = trk.bin - cfg_q.data_start;
		pass_in = (kind_in == ospt_pkg::KIND_DATA || kind_in == ospt_pkg::KIND_PILOT
				|| kind_in == ospt_pkg::KIND_CAL)
			&& (cfg_q.block_len != '0)
			&& (trk.bin >= cfg_q.data_start)
			&& ({1'b0, k_in} < trk.span);
		last_in = ({1'b0, k_in} + 13'd1) == trk.span;
	end

	// a dropped word leaves stage 1 without needing the result register
	assign m_fire        = m_axis_tvalid && m_axis_tready;
	assign out_free      = !valid_s2 || m_axis_tready;
	assign s1_move       = valid_s1 && (out_free || !pass_s1);
	assign s_axis_tready = !trk.busy && (!valid_s1 || s1_move);
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pass_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
			pass_s1  <= pass_in;
			last_s1  <= last_in;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.sample_re <= s_axis_tdata[15:0];
			item_s1.sample_im <= s_axis_tdata[31:16];
			item_s1.pilot_re  <= s_axis_tdata[47:32];
			item_s1.pilot_im  <= s_axis_tdata[63:48];
			item_s1.kind      <= kind_in;
			item_s1.ant       <= s_axis_tuser[7:2];
			item_s1.k         <= k_in;
			item_s1.off       <= trk.off;
			item_s1.base      <= trk.base;
		end
	end

	// ---------------------------------------------------------------
	// datapath and result register
	// ---------------------------------------------------------------
	ospt_dp u_dp (
		.item (item_s1),
		.cfg  (cfg_q),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1 && pass_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && pass_s1) begin
			res_s2  <= res_d;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, res_s2.value_im, res_s2.value_re, res_s2.dest_index};
	assign m_axis_tuser  = {res_s2.sat, res_s2.to_cal};
	assign m_axis_tlast  = last_s2;

`ifndef SYNTHESIS
	// a register write always forces a position recompute
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> trk.busy)
		else $error("tracker not busy after register write");

	// each accepted word steps the bin counter by one or wraps it to zero
	a_bin_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (trk.bin == '0 || trk.bin == 12'($past(trk.bin) + 12'd1)))
		else $error("bin counter skipped");

	// saturation only arises on pilot words, never on calibration words
	a_sat_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
		else $error("saturation flagged on calibration word");

	// nothing is taken while the tracker recomputes
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		trk.busy |-> !s_fire)
		else $error("word accepted during recompute");
`endif

endmodule

// ===== tb/ofdm_subcarrier_pilot_transpose_tb.sv =====
module ofdm_subcarrier_pilot_transpose_tb;

	// symbol kind with no enum member; the block drops it but still counts the bin
	localparam logic [1:0] KIND_RSVD = 2'd3;
	// cycles with no handshake at all before the run is called dead
	localparam int STALL_LIMIT = 2000;

	// one FFT bin word as driven on the slave side
	typedef struct packed {
		logic [15:0] sr;
		logic [15:0] si;
		logic [15:0] pr;
		logic [15:0] pi;
		logic [1:0]  kind;
		logic [5:0]  ant;
	} bin_t;

	// one placed result word as expected on the master side
	typedef struct packed {
		logic [17:0] dest;
		logic [15:0] re;
		logic [15:0] im;
		logic        cal;
		logic        sat;
		logic        last;
	} place_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [7:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	ofdm_subcarrier_pilot_transpose u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// words waiting for the driver, and placed results waiting for the monitor
	bin_t   bin_q[$];
	place_t placed_q[$];

	// shadow of the block's registers and bin counter
	int unsigned fft_reg   = ospt_pkg::FFT_SIZE_RST;
	int unsigned start_reg = ospt_pkg::DATA_START_RST;
	int unsigned count_reg = ospt_pkg::DATA_COUNT_RST;
	int unsigned blk_reg   = ospt_pkg::BLOCK_LEN_RST;
	int unsigned ants_reg  = ospt_pkg::ANT_COUNT_RST;
	logic [11:0] bin_pos   = '0;

	bit steady = 1'b0;  // no idling on either side while set
	int err_cnt = 0;
	int words_in = 0;
	int results = 0;
	int sat_seen = 0;
	int last_seen = 0;
	int settings = 0;
	int quiet = 0;

	bin_t on_bus = '0;  // word currently on the slave bus

	// Q3.30 product sum -> Q1.15: add half an LSB, arithmetic shift, clip
	function automatic logic [15:0] round_clip(input longint acc, inout bit clipped);
		longint q;
		q = (acc + 16384) >>> 15;
		if (q > 32767) begin
			clipped = 1'b1;
			return 16'h7FFF;
		end
		if (q < -32768) begin
			clipped = 1'b1;
			return 16'h8000;
		end
		return q[15:0];
	endfunction

	// Advances the bin counter for one accepted word; returns 1 and the placed result when the
	// bin falls in the passed span, the kind is not reserved and the block length is not zero.
	function automatic bit descramble_place(input bin_t w, output place_t p);
		int unsigned size, ants, bin, span, k;
		longint acc_re, acc_im;
		longint unsigned addr;
		bit clipped;
		p = '0;
		clipped = 1'b0;
		size = (fft_reg > ospt_pkg::MAX_FFT) ? ospt_pkg::MAX_FFT : fft_reg;
		ants = (ants_reg > ospt_pkg::MAX_ANTS) ? ospt_pkg::MAX_ANTS : ants_reg;
		bin = bin_pos;
		// size 0 or 1 pins the counter at 0
		bin_pos = (size <= 1 || bin + 1 >= size) ? 12'd0 : 12'(bin + 1);
		if (w.kind == KIND_RSVD || blk_reg == 0)
			return 1'b0;
		// only whole blocks pass; the tail of the data range is dropped
		span = (count_reg / blk_reg) * blk_reg;
		if (bin < start_reg)
			return 1'b0;
		k = bin - start_reg;
		if (k >= span)
			return 1'b0;
		p.re = w.sr;
		p.im = w.si;
		if (w.kind == ospt_pkg::KIND_PILOT) begin
			// bin times conj(pilot)
			acc_re = longint'($signed(w.sr)) * longint'($signed(w.pr))
				+ longint'($signed(w.si)) * longint'($signed(w.pi));
			acc_im = longint'($signed(w.si)) * longint'($signed(w.pr))
				- longint'($signed(w.sr)) * longint'($signed(w.pi));
			p.re = round_clip(acc_re, clipped);
			p.im = round_clip(acc_im, clipped);
		end
		if (w.kind == ospt_pkg::KIND_CAL)
			addr = longint'(w.ant) * count_reg + k;
		else
			addr = longint'(k / blk_reg) * blk_reg * ants + longint'(w.ant) * blk_reg
				+ k % blk_reg;
		p.dest = addr[17:0];  // wraps modulo 2^18
		p.cal  = (w.kind == ospt_pkg::KIND_CAL);
		p.sat  = clipped;
		p.last = (k + 1 == span);
		return 1'b1;
	endfunction

	task automatic flag_err(input string msg);
		$display("mismatch: %s", msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [17:0] got, input logic [17:0] want);
		if (got !== want)
			flag_err($sformatf("%s got %h want %h at result %0d", name, got, want, results));
	endtask

	// Q1.15 value with the extremes well represented
	function automatic logic [15:0] rand_q15();
		case ($urandom_range(11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_bin(input logic [15:0] sr, si, pr, pi, input logic [1:0] kind,
			input logic [5:0] ant);
		bin_t w;
		w = '{sr: sr, si: si, pr: pr, pi: pi, kind: kind, ant: ant};
		bin_q.push_back(w);
	endtask

	// Symbols of one kind and antenna with random content; a few words are noise
	// with a random kind (reserved one included) and antenna.
	task automatic fill_symbols(input int n);
		int run_len, left;
		logic [1:0] sym_kind;
		logic [5:0] sym_ant;
		bin_t w;
		run_len = (fft_reg > 4096) ? 4096 : ((fft_reg < 2) ? 16 : fft_reg);
		if (run_len > 256)
			run_len = 256;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = run_len;
				sym_kind = ($urandom_range(99) < 6) ? KIND_RSVD : 2'($urandom_range(2));
				sym_ant = 6'($urandom_range(63));
				if (ants_reg != 0 && $urandom_range(1))
					sym_ant = 6'($urandom_range(ants_reg - 1));
			end
			left--;
			w.sr = rand_q15();
			w.si = rand_q15();
			w.pr = rand_q15();
			w.pi = rand_q15();
			w.kind = sym_kind;
			w.ant = sym_ant;
			if ($urandom_range(99) < 8) begin
				w.kind = 2'($urandom_range(3));
				w.ant = 6'($urandom);
			end
			bin_q.push_back(w);
		end
	endtask

	// wait until every word is in and every result out, then let the pipe drain
	task automatic settle();
		do @(negedge clk); while (bin_q.size() != 0 || s_axis_tvalid || placed_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input ospt_pkg::reg_idx_t idx, input logic [12:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ospt_pkg::REG_FFT_SIZE:   fft_reg = val;
			ospt_pkg::REG_DATA_START: start_reg = val[11:0];
			ospt_pkg::REG_DATA_COUNT: count_reg = val;
			ospt_pkg::REG_BLOCK_LEN:  blk_reg = val;
			ospt_pkg::REG_ANT_COUNT:  ants_reg = val[6:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(input logic [12:0] fft, start, cnt, blk, ants);
		write_reg(ospt_pkg::REG_FFT_SIZE, fft);
		write_reg(ospt_pkg::REG_DATA_START, start);
		write_reg(ospt_pkg::REG_DATA_COUNT, cnt);
		write_reg(ospt_pkg::REG_BLOCK_LEN, blk);
		write_reg(ospt_pkg::REG_ANT_COUNT, ants);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic [12:0] fft, start, cnt, blk, ants, input int n,
			input bit calm);
		settle();
		apply_cfg(fft, start, cnt, blk, ants);
		@(negedge clk);
		steady = calm;
		fill_symbols(n);
	endtask

	// Driver: presents the next queued word, holds it until accepted, and
	// predicts its result at the accepting edge.
	always @(posedge clk or negedge arst_n) begin : feed
		bin_t nxt;
		place_t exp_res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				words_in++;
				if (descramble_place(on_bus, exp_res))
					placed_q.push_back(exp_res);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (bin_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
					nxt = bin_q.pop_front();
					on_bus <= nxt;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {nxt.pi, nxt.pr, nxt.si, nxt.sr};
					s_axis_tuser <= {nxt.ant, nxt.kind};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure; each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : check
		place_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (placed_q.size() == 0) begin
					flag_err($sformatf("result word dest %h with nothing expected",
						m_axis_tdata[17:0]));
				end else begin
					want = placed_q.pop_front();
					check_field("dest_index", m_axis_tdata[17:0], want.dest);
					check_field("value_re", 18'(m_axis_tdata[33:18]), 18'(want.re));
					check_field("value_im", 18'(m_axis_tdata[49:34]), 18'(want.im));
					check_field("to_calibration", 18'(m_axis_tuser[0]), 18'(want.cal));
					check_field("saturated", 18'(m_axis_tuser[1]), 18'(want.sat));
					check_field("last", 18'(m_axis_tlast), 18'(want.last));
					results++;
					if (want.sat)
						sat_seen++;
					if (want.last)
						last_seen++;
				end
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 11);
		end
	end

	// watchdog: a run with no handshake and no register write for too long is dead
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("ofdm_subcarrier_pilot_transpose_tb NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: bins below 424 drop, 424..431 land in block 0
		@(negedge clk);
		fill_symbols(432);

		// directed symbol: size 16, span 2..9 (count 10 leaves a partial block), block 4, three antennas
		settle();
		apply_cfg(13'd16, 13'd2, 13'd10, 13'd4, 13'd3);
		@(negedge clk);
		// counter sits past the new size: this word drops and wraps it to 0
		push_bin(16'h1234, 16'h5678, 16'h0000, 16'h0000, ospt_pkg::KIND_DATA, 6'd0);
		// before span
		push_bin(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, ospt_pkg::KIND_DATA, 6'd0);
		push_bin(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, KIND_RSVD, 6'd63);  // reserved kind
		// re clips
		push_bin(16'h8000, 16'h8000, 16'h8000, 16'h8000, ospt_pkg::KIND_PILOT, 6'd1);
		// im clips
		push_bin(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, ospt_pkg::KIND_PILOT, 6'd2);
		push_bin(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, ospt_pkg::KIND_PILOT, 6'd2);
		// calibration
		push_bin(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, ospt_pkg::KIND_CAL, 6'd63);
		// antenna past count
		push_bin(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, ospt_pkg::KIND_DATA, 6'd63);
		push_bin(16'h0001, 16'h0001, 16'h0000, 16'h0000, KIND_RSVD, 6'd1);   // counted, no word
		// small negatives
		push_bin(16'hFFFD, 16'h0005, 16'h4000, 16'hC000, ospt_pkg::KIND_PILOT, 6'd0);
		// last of span
		push_bin(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, ospt_pkg::KIND_DATA, 6'd0);
		// partial block
		push_bin(16'h4000, 16'hC000, 16'h0000, 16'h0000, ospt_pkg::KIND_DATA, 6'd1);
		push_bin(16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF, ospt_pkg::KIND_PILOT, 6'd1);
		push_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ospt_pkg::KIND_DATA, 6'd2);
		push_bin(16'h8000, 16'h8000, 16'h8000, 16'h8000, ospt_pkg::KIND_CAL, 6'd2);
		push_bin(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, ospt_pkg::KIND_PILOT, 6'd0);
		push_bin(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, ospt_pkg::KIND_DATA, 6'd3);
		// next symbol
		push_bin(16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000, ospt_pkg::KIND_DATA, 6'd0);
		push_bin(16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, ospt_pkg::KIND_PILOT, 6'd1);
		push_bin(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, ospt_pkg::KIND_CAL, 6'd0);
		push_bin(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, ospt_pkg::KIND_PILOT, 6'd3);

		// random phases: size, start, count, block, antennas, words
		run_phase(13'd64, 13'd8, 13'd48, 13'd8, 13'd4, 150, 1'b1);          // whole blocks
		run_phase(13'd8, 13'd0, 13'd8, 13'd8, 13'd1, 120, 1'b0);            // minimum sizes
		run_phase(13'd40, 13'd3, 13'd37, 13'd5, 13'd64, 150, 1'b0);         // odd block, partial
		run_phase(13'd24, 13'd0, 13'd24, 13'd24, 13'd2, 120, 1'b0);         // one block/symbol
		run_phase(13'd0, 13'd0, 13'd16, 13'd8, 13'd127, 80, 1'b0);          // counter pinned
		run_phase(13'd1, 13'd0, 13'd8, 13'd1, 13'd2, 60, 1'b0);             // size 1, block 1
		run_phase(13'd32, 13'd4, 13'd20, 13'd0, 13'd8, 60, 1'b0);           // zero block length
		run_phase(13'd16, 13'd2, 13'd12, 13'd4, 13'd0, 80, 1'b0);           // no antennas
		run_phase(13'd2, 13'h1000, 13'd8, 13'd8, 13'd3, 60, 1'b0);          // start bit 12 unused
		run_phase(13'd200, 13'd150, 13'd4096, 13'd16, 13'd5, 250, 1'b0);    // count past symbol
		run_phase(13'd48, 13'd0, 13'h1FFF, 13'd4096, 13'd64, 60, 1'b0);     // largest count/block
		run_phase(13'd8, 13'd4095, 13'd8, 13'd8, 13'd1, 30, 1'b0);          // start out of reach
		run_phase(13'h1FFF, 13'd0, 13'd16, 13'd8, 13'd64, 100, 1'b0);       // size above the clip

		settle();
		repeat (8) @(posedge clk);
		$display("%0d bin words sent, %0d placed results checked over %0d register settings",
			words_in, results, settings);
		$display("%0d clipped pilot products, %0d span ends seen", sat_seen, last_seen);
		if (err_cnt == 0)
			$display("ofdm_subcarrier_pilot_transpose_tb OK");
		else
			$display("ofdm_subcarrier_pilot_transpose_tb NOT OK");
		$finish;
	end

endmodule
